// ===== design/sfc_pkg.sv =====
package sfc_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion constants, results in hundredths
  localparam logic [14:0] T_SCALE  = 15'd17500;
  localparam logic [14:0] T_OFFSET = 15'd4500;
  localparam logic [13:0] H_SCALE  = 14'd10000;
  localparam logic [15:0] RAW_FULL = 16'hFFFF;

  typedef struct packed {
    logic        done;
    logic        bad;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/sfc_if.sv =====
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface sfc_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;

  modport source (output valid, status, temperature_centi, humidity_centi, input ready);
  modport sink (input valid, status, temperature_centi, humidity_centi, output ready);
endinterface

// ===== design/sfc_frame.sv =====
module sfc_frame (
  input  logic           clk,
  input  logic           rst_n,
  sfc_in_if.sink         in_ch,
  input  logic           take,
  output sfc_pkg::frame_t frame
);
  import sfc_pkg::*;

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] word_r, word_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic        fail_r, fail_nxt;
  logic        accept;
  logic [2:0]  pos;
  logic [7:0]  b;

  assign in_ch.ready = take;
  assign accept      = in_ch.valid && take;
  assign b           = in_ch.rx_byte;
  // frame_start resyncs the count to the first byte
  assign pos = (in_ch.frame_start || pos_r > POS_H_CRC) ? POS_T_MSB : pos_r;

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    word_nxt = word_r;
    temp_nxt = temp_r;
    fail_nxt = fail_r;
    if (accept) begin
      pos_nxt = pos + 3'd1;
      unique case (pos) inside
        POS_T_MSB, POS_H_MSB: begin
          word_nxt = {b, 8'h00};
          crc_nxt  = crc8_update(CRC_INIT, b);
          if (pos == POS_T_MSB) fail_nxt = 1'b0;
        end
        POS_T_LSB, POS_H_LSB: begin
          word_nxt = word_r | {8'h00, b};
          crc_nxt  = crc8_update(crc_r, b);
        end
        POS_T_CRC: begin
          if (crc_r != b) fail_nxt = 1'b1;
          temp_nxt = word_r;
          crc_nxt  = CRC_INIT;
        end
        default: begin
          pos_nxt  = POS_T_MSB;
          crc_nxt  = CRC_INIT;
          fail_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_T_MSB;
      crc_r  <= CRC_INIT;
      word_r <= '0;
      temp_r <= '0;
      fail_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      word_r <= word_nxt;
      temp_r <= temp_nxt;
      fail_r <= fail_nxt;
    end
  end

  assign frame.done     = accept && (pos == POS_H_CRC);
  assign frame.bad      = fail_r || (crc_r != b);
  assign frame.temp_raw = temp_r;
  assign frame.hum_raw  = word_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= POS_H_CRC)
    else $error("byte position out of range");
  a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |=> (pos_r == POS_T_MSB && crc_r == CRC_INIT && !fail_r))
    else $error("frame end did not restart the count");

endmodule

// ===== design/sfc_scale.sv =====
module sfc_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  sfc_pkg::frame_t frame,
  output logic            take,
  sfc_out_if.source       out_ch
);
  import sfc_pkg::*;

  logic        prod_v_r, prod_v_nxt;
  logic        bad_r;
  logic [30:0] tprod_r;
  logic [29:0] hprod_r;
  logic        out_v_r, out_v_nxt;
  logic        status_r;
  logic [14:0] temp_r;
  logic [13:0] hum_r;
  logic        adv_out;

  logic [14:0] tq, tquo, tval;
  logic [16:0] trem;
  logic [13:0] hq, hquo;
  logic [16:0] hrem;

  assign adv_out    = !out_v_r || out_ch.ready;
  assign take       = !prod_v_r || adv_out;
  assign prod_v_nxt = take ? frame.done : prod_v_r;
  assign out_v_nxt  = adv_out ? prod_v_r : out_v_r;

  // x / 65535 as x >> 16 plus one correction: remainder is low half + quotient
  assign tq   = tprod_r[30:16];
  assign trem = {1'b0, tprod_r[15:0]} + {2'b00, tq};
  assign tquo = tq + {14'd0, (trem >= {1'b0, RAW_FULL})};
  assign tval = tquo - T_OFFSET;

  assign hq   = hprod_r[29:16];
  assign hrem = {1'b0, hprod_r[15:0]} + {3'b000, hq};
  assign hquo = hq + {13'd0, (hrem >= {1'b0, RAW_FULL})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame.done) begin
      bad_r   <= frame.bad;
      tprod_r <= {16'd0, T_SCALE} * {15'd0, frame.temp_raw};
      hprod_r <= {16'd0, H_SCALE} * {14'd0, frame.hum_raw};
    end
    if (adv_out && prod_v_r) begin
      status_r <= bad_r;
      temp_r   <= bad_r ? 15'd0 : tval;
      hum_r    <= bad_r ? 14'd0 : hquo;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.status            = status_r;
  assign out_ch.temperature_centi = signed'(temp_r);
  assign out_ch.humidity_centi    = hum_r;

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.status) |->
      (out_ch.humidity_centi <= 14'd10000 && out_ch.temperature_centi >= -15'sd4500
       && out_ch.temperature_centi <= 15'sd13000))
    else $error("converted value out of range");
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_v_r && !adv_out) |=> prod_v_r)
    else $error("product stage dropped a word");

endmodule

// ===== design/sensor_frame_crc_convert.sv =====
// channel  dir  handshake            payload
// in_ch    in   valid/ready          rx_byte[7:0], frame_start
// out_ch   out  valid/ready          status, temperature_centi[14:0] (signed),
//                                    humidity_centi[13:0]
//
// one byte accepted per cycle while in_ch.ready is high; a result passes the
// product and output registers after the sixth byte; crc is updated in the
// byte cycle, scale multiply and /65535 correction: one registered stage each
// rst_n is synchronous: byte count to zero, crc to 0xff, pipeline emptied
// out_ch.ready low stalls the two result stages; in_ch.ready drops only when
// both hold a word
module sensor_frame_crc_convert (
  input  logic      clk,
  input  logic      rst_n,
  sfc_in_if.sink    in_ch,
  sfc_out_if.source out_ch
);
  import sfc_pkg::*;

  frame_t frame;
  logic   take;

  sfc_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .frame (frame)
  );

  sfc_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .frame  (frame),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/sensor_frame_crc_convert_checker.sv =====
module sensor_frame_crc_convert_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [7:0]  in_rx_byte,
  input  logic               in_frame_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_status,
  input  logic signed [14:0] out_temperature_centi,
  input  logic        [13:0] out_humidity_centi,
  output int                 fail_count,
  output int                 readings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // byte slots of one measurement frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  localparam logic [7:0]  CRC_SEED   = 8'hFF;
  localparam logic [7:0]  CRC_GEN    = 8'h31;
  localparam logic [31:0] TEMP_SPAN  = 32'd17500;
  localparam logic [31:0] TEMP_SHIFT = 32'd4500;
  localparam logic [31:0] HUM_SPAN   = 32'd10000;
  localparam logic [31:0] RAW_MAX    = 32'd65535;

  typedef struct packed {
    logic        status;
    logic [14:0] temp;
    logic [13:0] hum;
  } reading_t;

  reading_t    expected_readings[$];
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [15:0] word_acc;
  logic [15:0] temp_hold;
  logic        crc_bad;

  initial fail_count = 0;

  // msb-first serial form of the 0x31 generator
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_GEN : 8'h00);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic [2:0]  pos;
    logic [31:0] tq;
    logic [31:0] hq;
    logic [31:0] tdiff;
    reading_t    r;
    pos = (fs || frame_pos > POS_H_CRC) ? POS_T_MSB : frame_pos;
    case (pos)
      POS_T_MSB, POS_H_MSB: begin
        if (pos == POS_T_MSB) crc_bad = 1'b0;
        word_acc = {b, 8'h00};
        crc_acc = crc_step(CRC_SEED, b);
      end
      POS_T_LSB, POS_H_LSB: begin
        word_acc = word_acc | {8'h00, b};
        crc_acc = crc_step(crc_acc, b);
      end
      POS_T_CRC: begin
        if (crc_acc != b) crc_bad = 1'b1;
        temp_hold = word_acc;
        crc_acc = CRC_SEED;
      end
      default: begin
        r = '0;
        if (crc_bad || crc_acc != b) begin
          r.status = STATUS_CRC_ERR;
        end else begin
          tq = (TEMP_SPAN * {16'd0, temp_hold}) / RAW_MAX;
          hq = (HUM_SPAN * {16'd0, word_acc}) / RAW_MAX;
          tdiff = tq - TEMP_SHIFT;
          r.status = STATUS_OK;
          r.temp = tdiff[14:0];
          r.hum = hq[13:0];
        end
        expected_readings.push_back(r);
        crc_acc = CRC_SEED;
        crc_bad = 1'b0;
      end
    endcase
    frame_pos = (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
  endtask

  task automatic check_reading();
    reading_t r;
    if (expected_readings.size() == 0) begin
      report_mismatch("result word with no completed frame pending");
    end else begin
      r = expected_readings.pop_front();
      if (out_status !== r.status)
        report_mismatch($sformatf("status %b, want %b", out_status, r.status));
      if (out_temperature_centi !== r.temp)
        report_mismatch($sformatf("temperature %0d, want %0d",
                                  out_temperature_centi, $signed(r.temp)));
      if (out_humidity_centi !== r.hum)
        report_mismatch($sformatf("humidity %0d, want %0d", out_humidity_centi, r.hum));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos = POS_T_MSB;
      crc_acc = CRC_SEED;
      word_acc = '0;
      temp_hold = '0;
      crc_bad = 1'b0;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) check_reading();
      if (in_valid && in_ready) decode_byte(in_rx_byte, in_frame_start);
    end
    readings_pending <= expected_readings.size();
  end

endmodule

// ===== sim/sensor_frame_crc_convert_test.sv =====
module sensor_frame_crc_convert_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLDOFF_FROM = 600;
  localparam int HOLDOFF_LEN  = 150;
  localparam int CALM_RX_FROM = 1000;
  localparam int CALM_RX_TO   = 1300;
  localparam int CALM_TX_FROM = 400;
  localparam int CALM_TX_TO   = 650;
  localparam logic [7:0] CRC_SEED = 8'hFF;
  localparam logic [7:0] CRC_GEN  = 8'h31;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   readings_pending;
  int   sent_items = 0;
  int   rx_cycle = 0;

  sfc_in_if  in_ch ();
  sfc_out_if out_ch ();

  sensor_frame_crc_convert u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sensor_frame_crc_convert_checker u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_ch.valid),
    .in_ready              (in_ch.ready),
    .in_rx_byte            (in_ch.rx_byte),
    .in_frame_start        (in_ch.frame_start),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_status            (out_ch.status),
    .out_temperature_centi (out_ch.temperature_centi),
    .out_humidity_centi    (out_ch.humidity_centi),
    .fail_count            (fail_count),
    .readings_pending      (readings_pending)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] crc_of_word(input logic [15:0] w);
    logic [7:0] c;
    c = CRC_SEED;
    for (int i = 15; i >= 0; i--) begin
      c = c[7] ^ w[i] ? ({c[6:0], 1'b0} ^ CRC_GEN) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: w = 16'h0000;
        1: w = 16'h0001;
        2: w = 16'hFFFE;
        default: w = 16'hFFFF;
      endcase
    end
    return w;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    while (!(sent_items >= CALM_TX_FROM && sent_items < CALM_TX_TO) &&
           $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic fs,
                            input logic spoil_t, input logic spoil_h);
    logic [7:0] ct;
    logic [7:0] chum;
    logic [7:0] flip;
    flip = 8'($urandom_range(1, 255));
    ct = crc_of_word(t) ^ (spoil_t ? flip : 8'h00);
    flip = 8'($urandom_range(1, 255));
    chum = crc_of_word(h) ^ (spoil_h ? flip : 8'h00);
    send_byte(t[15:8], fs);
    send_byte(t[7:0], 1'b0);
    send_byte(ct, 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(chum, 1'b0);
  endtask

  // result side: random stalls, one long hold-off, one calm stretch
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_cycle >= HOLDOFF_FROM && rx_cycle < HOLDOFF_FROM + HOLDOFF_LEN)
        out_ch.ready <= 1'b0;
      else if (rx_cycle >= CALM_RX_FROM && rx_cycle < CALM_RX_TO)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(99) >= 36);
      @(posedge clk);
      rx_cycle++;
    end
  end

  initial begin
    int         kind;
    int         n;
    logic       resync;
    logic       spoil_t;
    logic       fs;
    logic [7:0] b;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.frame_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of both conversions, second frame without frame_start
    send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    // partial frame dropped by resync
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b0);
    send_frame(16'h1234, 16'h0001, 1'b0, 1'b0, 1'b1);

    resync = 1'b0;
    n = sent_items + RANDOM_ITEMS;
    while (sent_items < n) begin
      kind = $urandom_range(99);
      fs = resync || $urandom_range(1);
      if (kind < 75) begin
        send_frame(pick_word(), pick_word(), fs, 1'b0, 1'b0);
        resync = 1'b0;
      end else if (kind < 88) begin
        spoil_t = 1'($urandom_range(1));
        send_frame(pick_word(), pick_word(), fs, spoil_t, !spoil_t || $urandom_range(1));
        resync = 1'b0;
      end else begin
        // noise and broken frames
        repeat ($urandom_range(1, 5)) begin
          b = 8'($urandom);
          send_byte(b, $urandom_range(3) == 0);
        end
        resync = 1'b1;
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (readings_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
design/sfc_pkg.sv
design/sfc_if.sv
design/sfc_frame.sv
design/sfc_scale.sv
design/sensor_frame_crc_convert.sv
sim/sensor_frame_crc_convert_checker.sv
sim/sensor_frame_crc_convert_test.sv
